// ===== hdl/bfa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the bitmap frame allocator: operation codes,
// register indexes, controller states and the run finder result.
// ----------------------------------------------------------------------------
package bfa_pkg;

	// field and counter widths
	localparam int FRAME_W = 21;
	localparam int CNT_W   = 20;
	localparam int LEN_W   = 17;
	localparam int BASE_W  = 16;

	// kernel reservation made by every init
	localparam logic [FRAME_W-1:0] KERNEL_FIRST  = 21'd256;
	localparam logic [LEN_W-1:0]   KERNEL_FRAMES = 17'd1024;

	// memory types that own a region
	localparam logic [1:0] MEM_NORMAL = 2'd0;
	localparam logic [1:0] MEM_FAST   = 2'd1;

	// configuration register indexes
	localparam logic [1:0] REG_NORMAL_START  = 2'd0;
	localparam logic [1:0] REG_NORMAL_LENGTH = 2'd1;
	localparam logic [1:0] REG_FAST_START    = 2'd2;
	localparam logic [1:0] REG_FAST_LENGTH   = 2'd3;

	typedef enum logic [1:0] {
		OP_INIT  = 2'd0,
		OP_ALLOC = 2'd1,
		OP_FREE  = 2'd2,
		OP_MARK  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_RESET_FILL,
		ST_IDLE,
		ST_INIT_FILL,
		ST_INIT_NORMAL,
		ST_INIT_FAST,
		ST_INIT_KERNEL,
		ST_SCAN,
		ST_MARK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic               hit;
		logic [FRAME_W-1:0] start;
		logic [LEN_W-1:0]   run;
		logic [FRAME_W-1:0] first;
	} find_res_t;

endpackage
`default_nettype wire

// ===== hdl/bfa_map_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_map_ram
// Used-frame bitmap storage: one write port and one read port, registered
// read data.
// ----------------------------------------------------------------------------
module bfa_map_ram #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/bfa_run_finder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_run_finder
// Evaluates one bitmap word of a first-fit scan: finds the lowest frame at
// which a free run of the requested length completes, else carries the run.
// ----------------------------------------------------------------------------
module bfa_run_finder #(
	parameter int W = 32
) (
	input  wire logic [W-1:0]               used_word,
	input  wire logic [bfa_pkg::LEN_W-1:0]   run_in,
	input  wire logic [bfa_pkg::FRAME_W-1:0] first_in,
	input  wire logic [bfa_pkg::LEN_W-1:0]   need,
	input  wire logic [bfa_pkg::FRAME_W-1:0] word_base,
	output bfa_pkg::find_res_t               res
);

	localparam int LW = $clog2(W);
	localparam int LN = bfa_pkg::LEN_W;
	localparam int FW = bfa_pkg::FRAME_W;

	logic [W-1:0]  hit_vec;
	logic [W-1:0]  win;
	logic [W-1:0]  pre;
	logic [LW:0]   n_small;
	logic [LW-1:0] hj;
	logic [LW-1:0] hu;

	always_comb begin
		// window length when it fits in one word
		n_small = (need <= LN'(W)) ? need[LW:0] : '0;
		hit_vec = '0;
		win     = '0;
		pre     = '0;
		// each bit: does a free run of the needed length end here
		for (int j = 0; j < W; j++) begin
			win = ({W{1'b1}} >> (W - n_small)) << ((LW+1)'(j + 1) - n_small);
			pre = {W{1'b1}} >> (W - 1 - j);
			if (need <= LN'(j + 1)) begin
				hit_vec[j] = ~|(used_word & win);
			end else begin
				hit_vec[j] = (~|(used_word & pre)) &&
					(({1'b0, run_in} + (LN+1)'(j + 1)) >= {1'b0, need});
			end
		end
		// lowest completing bit
		hj = '0;
		for (int j = W - 1; j >= 0; j--) begin
			if (hit_vec[j]) begin
				hj = LW'(j);
			end
		end
		// highest used bit
		hu = '0;
		for (int j = 0; j < W; j++) begin
			if (used_word[j]) begin
				hu = LW'(j);
			end
		end
		res.hit = |hit_vec;
		if ({1'b0, need} <= ((LN+1)'(hj) + (LN+1)'(1))) begin
			res.start = word_base + FW'(hj) + FW'(1) - FW'(need);
		end else begin
			res.start = first_in;
		end
		// carry the open run into the next word
		if (~|used_word) begin
			res.run   = run_in + LN'(W);
			res.first = (run_in == '0) ? word_base : first_in;
		end else begin
			res.run   = LN'(W - 1) - LN'(hu);
			res.first = word_base + FW'(hu) + FW'(1);
		end
	end

endmodule
`default_nettype wire

// ===== hdl/bitmap_frame_allocator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_unit
// First-fit page-frame allocator over a one-bit-per-frame used map.
// ----------------------------------------------------------------------------
// Usage: items enter on in_valid/in_ready (op, frame_count, mem_type,
// base_frame); each item yields one result beat on out_valid/out_ready.
// Region registers are written through cfg_we/cfg_index/cfg_data, by the
// user only while idle; the block itself does not enforce it. The map
// lives in a RAM of NUM_FRAMES/MAP_WORD_BITS words with registered read
// data. A run write or a scan streams one map word per cycle through the
// RAM read port and the modify/write or search stage behind it.
// Free and mark touch the words of their run; allocate scans words and
// then marks the run that it found; init fills every map word, 2048 at
// the default size, and then writes the three region runs.
// Reset: the map is filled with ones, one word a cycle over all
// NUM_FRAMES/MAP_WORD_BITS words, during which in_ready stays low.
// Throughput: one item at a time. A finished result waits in an output
// register until out_ready; the next item is taken while it waits.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_unit #(
	parameter int NUM_FRAMES    = 65536,
	parameter int MAP_WORD_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [16:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [16:0] frame_count,
	input  wire logic [1:0]  mem_type,
	input  wire logic [15:0] base_frame,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             ok,
	output logic [15:0]      start_frame,
	output logic [19:0]      free_frames,
	output logic [19:0]      used_frames,
	output logic [19:0]      available_frames
);

	localparam int W     = MAP_WORD_BITS;
	localparam int LW    = $clog2(W);
	localparam int DEPTH = NUM_FRAMES / MAP_WORD_BITS;
	localparam int AW    = $clog2(DEPTH);
	localparam int FW    = bfa_pkg::FRAME_W;
	localparam int LN    = bfa_pkg::LEN_W;
	localparam int CW    = bfa_pkg::CNT_W;
	localparam logic [FW-1:0] NUM_F = FW'(NUM_FRAMES);

	// configuration registers
	logic [15:0]   normal_start_q;
	logic [LN-1:0] normal_len_q;
	logic [15:0]   fast_start_q;
	logic [LN-1:0] fast_len_q;

	// counters and control
	bfa_pkg::state_t state_q, state_d;
	logic [CW-1:0] free_q, used_q, avail_q;
	logic [AW-1:0] fill_q;
	logic          out_valid_q;

	// sweep engine
	logic          active_q;
	logic [AW-1:0] wi_q, sw_q, ew_q;
	logic [LW-1:0] lo_bit_q, hi_bit_q;
	logic          set_q, scan_q;
	logic          v_s1, first_s1, last_s1;
	logic [AW-1:0] wa_s1;
	logic [LN-1:0] run_q;
	logic [FW-1:0] first_q;

	// request and result payload
	logic [LN-1:0] need_q;
	logic          res_ok_q;
	logic [15:0]   res_start_q;
	logic          out_ok_q;
	logic [15:0]   out_start_q;
	logic [CW-1:0] out_free_q, out_used_q, out_avail_q;

	// controller outputs
	logic          accept;
	logic          launch;
	logic [FW-1:0] l_lo;
	logic [LN-1:0] l_n;
	logic          l_set, l_scan;
	logic          fail, hit_take, out_load, fill_we;

	// datapath nets
	logic [W-1:0]  rdata, wdata, mask;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic          busy;
	logic [FW-1:0] l_end, l_hi, l_last;
	logic          l_valid;
	logic [FW-1:0] rs, word_base;
	logic [LN-1:0] rl;
	bfa_pkg::find_res_t fres;

	assign busy = active_q | v_s1;
	assign rs   = (mem_type == bfa_pkg::MEM_FAST) ? FW'(fast_start_q) : FW'(normal_start_q);
	assign rl   = (mem_type == bfa_pkg::MEM_FAST) ? fast_len_q : normal_len_q;

	// next state and controls
	always_comb begin
		state_d  = state_q;
		accept   = 1'b0;
		launch   = 1'b0;
		l_lo     = '0;
		l_n      = '0;
		l_set    = 1'b0;
		l_scan   = 1'b0;
		fail     = 1'b0;
		hit_take = 1'b0;
		out_load = 1'b0;
		fill_we  = 1'b0;
		in_ready = 1'b0;
		case (state_q)
			bfa_pkg::ST_RESET_FILL: begin
				fill_we = 1'b1;
				if (fill_q == AW'(DEPTH - 1)) begin
					state_d = bfa_pkg::ST_IDLE;
				end
			end
			bfa_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					accept = 1'b1;
					case (op)
						bfa_pkg::OP_INIT: begin
							state_d = bfa_pkg::ST_INIT_FILL;
						end
						bfa_pkg::OP_ALLOC: begin
							if (frame_count == '0 ||
							    (mem_type != bfa_pkg::MEM_NORMAL &&
							     mem_type != bfa_pkg::MEM_FAST) ||
							    CW'(frame_count) > free_q || rl < frame_count ||
							    rs >= NUM_F) begin
								fail    = 1'b1;
								state_d = bfa_pkg::ST_DONE;
							end else begin
								launch  = 1'b1;
								l_lo    = rs;
								l_n     = rl;
								l_scan  = 1'b1;
								state_d = bfa_pkg::ST_SCAN;
							end
						end
						default: begin
							launch  = 1'b1;
							l_lo    = FW'(base_frame);
							l_n     = frame_count;
							l_set   = (op == bfa_pkg::OP_MARK);
							state_d = bfa_pkg::ST_MARK;
						end
					endcase
				end
			end
			bfa_pkg::ST_INIT_FILL: begin
				fill_we = 1'b1;
				if (fill_q == AW'(DEPTH - 1)) begin
					launch  = 1'b1;
					l_lo    = FW'(normal_start_q);
					l_n     = normal_len_q;
					state_d = bfa_pkg::ST_INIT_NORMAL;
				end
			end
			bfa_pkg::ST_INIT_NORMAL: begin
				if (!busy) begin
					launch  = 1'b1;
					l_lo    = FW'(fast_start_q);
					l_n     = fast_len_q;
					state_d = bfa_pkg::ST_INIT_FAST;
				end
			end
			bfa_pkg::ST_INIT_FAST: begin
				if (!busy) begin
					launch  = 1'b1;
					l_lo    = bfa_pkg::KERNEL_FIRST;
					l_n     = bfa_pkg::KERNEL_FRAMES;
					l_set   = 1'b1;
					state_d = bfa_pkg::ST_INIT_KERNEL;
				end
			end
			bfa_pkg::ST_INIT_KERNEL: begin
				if (!busy) begin
					state_d = bfa_pkg::ST_DONE;
				end
			end
			bfa_pkg::ST_SCAN: begin
				if (v_s1 && fres.hit) begin
					hit_take = 1'b1;
					launch   = 1'b1;
					l_lo     = fres.start;
					l_n      = need_q;
					l_set    = 1'b1;
					state_d  = bfa_pkg::ST_MARK;
				end else if (!busy) begin
					fail    = 1'b1;
					state_d = bfa_pkg::ST_DONE;
				end
			end
			bfa_pkg::ST_MARK: begin
				if (!busy) begin
					state_d = bfa_pkg::ST_DONE;
				end
			end
			bfa_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = bfa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bfa_pkg::ST_IDLE;
			end
		endcase
	end

	// launch range: clip the run at the end of the map
	assign l_end   = l_lo + FW'(l_n);
	assign l_hi    = (l_end > NUM_F) ? NUM_F : l_end;
	assign l_last  = l_hi - FW'(1);
	assign l_valid = (l_n != '0) && (l_lo < NUM_F);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= bfa_pkg::ST_RESET_FILL;
			fill_q         <= '0;
			active_q       <= 1'b0;
			v_s1           <= 1'b0;
			out_valid_q    <= 1'b0;
			free_q         <= '0;
			used_q         <= '0;
			avail_q        <= '0;
			normal_start_q <= '0;
			normal_len_q   <= '0;
			fast_start_q   <= '0;
			fast_len_q     <= '0;
		end else begin
			state_q <= state_d;
			// advance the fill sweep
			if (fill_we) begin
				fill_q <= (fill_q == AW'(DEPTH - 1)) ? '0 : fill_q + AW'(1);
			end
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					bfa_pkg::REG_NORMAL_START:  normal_start_q <= cfg_data[15:0];
					bfa_pkg::REG_NORMAL_LENGTH: normal_len_q   <= cfg_data;
					bfa_pkg::REG_FAST_START:    fast_start_q   <= cfg_data[15:0];
					bfa_pkg::REG_FAST_LENGTH:   fast_len_q     <= cfg_data;
					default: begin
					end
				endcase
			end
			// init resets the counters
			if (accept && op == bfa_pkg::OP_INIT) begin
				avail_q <= CW'({1'b0, normal_len_q} + {1'b0, fast_len_q});
				used_q  <= CW'({1'b0, normal_len_q} + {1'b0, fast_len_q});
				free_q  <= '0;
			end
			// run writes adjust the counters up front
			if (launch && !l_scan && l_n != '0) begin
				if (l_set) begin
					used_q <= used_q + CW'(l_n);
					free_q <= free_q - CW'(l_n);
				end else begin
					used_q <= used_q - CW'(l_n);
					free_q <= free_q + CW'(l_n);
				end
			end
			// sweep issue and stage one
			if (launch) begin
				active_q <= l_valid;
				v_s1     <= 1'b0;
			end else begin
				v_s1 <= active_q;
				if (active_q && wi_q == ew_q) begin
					active_q <= 1'b0;
				end
			end
			// output beat
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// sweep and request payload
	always_ff @(posedge clk) begin
		if (launch) begin
			wi_q     <= l_lo[AW+LW-1:LW];
			sw_q     <= l_lo[AW+LW-1:LW];
			ew_q     <= l_last[AW+LW-1:LW];
			lo_bit_q <= l_lo[LW-1:0];
			hi_bit_q <= l_last[LW-1:0];
			set_q    <= l_set;
			scan_q   <= l_scan;
			run_q    <= '0;
			first_q  <= '0;
		end else begin
			if (active_q) begin
				wi_q <= wi_q + AW'(1);
			end
			// carry the open run between scanned words
			if (v_s1 && scan_q) begin
				run_q   <= fres.run;
				first_q <= fres.first;
			end
		end
		wa_s1    <= wi_q;
		first_s1 <= (wi_q == sw_q);
		last_s1  <= (wi_q == ew_q);
		if (accept) begin
			need_q <= frame_count;
		end
		// hold the pending result fields
		if (fail) begin
			res_ok_q    <= 1'b0;
			res_start_q <= '0;
		end else if (accept) begin
			res_ok_q    <= 1'b1;
			res_start_q <= '0;
		end else if (hit_take) begin
			res_start_q <= fres.start[15:0];
		end
		// result register
		if (out_load) begin
			out_ok_q    <= res_ok_q;
			out_start_q <= res_start_q;
			out_free_q  <= free_q;
			out_used_q  <= used_q;
			out_avail_q <= avail_q;
		end
	end

	// in-range bits of the word in stage one
	always_comb begin
		mask = {W{1'b1}};
		if (first_s1) begin
			mask = mask & ({W{1'b1}} << lo_bit_q);
		end
		if (last_s1) begin
			mask = mask & ({W{1'b1}} >> (LW'(W - 1) - hi_bit_q));
		end
	end

	// modify: set or clear the run, or fill with ones
	assign wdata     = fill_we ? {W{1'b1}} :
	                   (set_q ? (rdata | mask) : (rdata & ~mask));
	assign ram_we    = fill_we || (v_s1 && !scan_q);
	assign ram_waddr = fill_we ? fill_q : wa_s1;
	assign word_base = FW'({wa_s1, {LW{1'b0}}});

	bfa_map_ram #(
		.DEPTH(DEPTH),
		.WIDTH(W)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(wdata),
		.re   (active_q),
		.raddr(wi_q),
		.rdata(rdata)
	);

	bfa_run_finder #(
		.W(W)
	) u_finder (
		.used_word(rdata | ~mask),
		.run_in   (run_q),
		.first_in (first_q),
		.need     (need_q),
		.word_base(word_base),
		.res      (fres)
	);

	assign out_valid        = out_valid_q;
	assign ok               = out_ok_q;
	assign start_frame      = out_start_q;
	assign free_frames      = out_free_q;
	assign used_frames      = out_used_q;
	assign available_frames = out_avail_q;

endmodule
`default_nettype wire

// ===== tb/tb_bitmap_frame_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_frame_allocator_unit
// Self-checking bench for the first-fit frame allocator. A bit-level map
// predictor tracks every accepted beat, and each result beat is compared
// field by field. Region registers are swept through several settings,
// including the extremes, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_bitmap_frame_allocator_unit;

	localparam int MAP_FRAMES  = 65536;
	localparam int CYCLE_LIMIT = 8000000;

	typedef struct {
		logic        ok;
		logic [15:0] start;
		logic [19:0] free_n;
		logic [19:0] used_n;
		logic [19:0] avail_n;
	} alloc_res_t;

	// Frame map predictor plus the queue of outstanding results
	class frame_scoreboard;
		bit          used_bit [MAP_FRAMES];
		logic [15:0] n_start, f_start;
		logic [16:0] n_len, f_len;
		logic [19:0] free_cnt, used_cnt, avail_cnt;
		alloc_res_t  pending [$];
		int          mismatches;

		function new();
			foreach (used_bit[i]) used_bit[i] = 1'b1;
			n_start = '0; f_start = '0; n_len = '0; f_len = '0;
			free_cnt = '0; used_cnt = '0; avail_cnt = '0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [16:0] val);
			case (idx)
				bfa_pkg::REG_NORMAL_START:  n_start = val[15:0];
				bfa_pkg::REG_NORMAL_LENGTH: n_len   = val;
				bfa_pkg::REG_FAST_START:    f_start = val[15:0];
				bfa_pkg::REG_FAST_LENGTH:   f_len   = val;
				default: begin
				end
			endcase
		endfunction

		// set or clear a run; frames past the map are dropped
		function void set_run(int unsigned base, int unsigned n, bit val);
			if (n == 0) return;
			if (val) begin
				used_cnt = used_cnt + 20'(n);
				free_cnt = free_cnt - 20'(n);
			end else begin
				used_cnt = used_cnt - 20'(n);
				free_cnt = free_cnt + 20'(n);
			end
			for (int unsigned i = 0; i < n; i++)
				if (base + i < MAP_FRAMES) used_bit[base + i] = val;
		endfunction

		function bit first_fit(int unsigned n, logic [1:0] mt, output int unsigned at);
			int unsigned rs, rl, run, first, f;
			run = 0; first = 0; at = 0;
			if (n == 0 || (mt != bfa_pkg::MEM_NORMAL && mt != bfa_pkg::MEM_FAST) ||
			    n > free_cnt)
				return 1'b0;
			rs = (mt == bfa_pkg::MEM_FAST) ? f_start : n_start;
			rl = (mt == bfa_pkg::MEM_FAST) ? f_len : n_len;
			if (rl < n) return 1'b0;
			for (int unsigned i = 0; i < rl; i++) begin
				f = rs + i;
				if (f < MAP_FRAMES && !used_bit[f]) begin
					if (run == 0) first = f;
					run++;
					if (run == n) begin
						set_run(first, n, 1'b1);
						at = first;
						return 1'b1;
					end
				end else begin
					run = 0;
				end
			end
			return 1'b0;
		endfunction

		// note an accepted input beat and queue its expected result
		function alloc_res_t note(bfa_pkg::op_t o, logic [16:0] cnt, logic [1:0] mt,
				logic [15:0] base);
			alloc_res_t  r;
			int unsigned at;
			r.ok = 1'b1; r.start = '0;
			case (o)
				bfa_pkg::OP_INIT: begin
					avail_cnt = 20'(n_len) + 20'(f_len);
					foreach (used_bit[i]) used_bit[i] = 1'b1;
					free_cnt = '0;
					used_cnt = avail_cnt;
					set_run(n_start, n_len, 1'b0);
					set_run(f_start, f_len, 1'b0);
					set_run(bfa_pkg::KERNEL_FIRST, bfa_pkg::KERNEL_FRAMES, 1'b1);
				end
				bfa_pkg::OP_ALLOC: begin
					r.ok = first_fit(cnt, mt, at);
					r.start = r.ok ? at[15:0] : 16'd0;
				end
				bfa_pkg::OP_FREE: set_run(base, cnt, 1'b0);
				default: set_run(base, cnt, 1'b1);
			endcase
			r.free_n = free_cnt; r.used_n = used_cnt; r.avail_n = avail_cnt;
			pending.push_back(r);
			return r;
		endfunction

		function void check(alloc_res_t got);
			alloc_res_t exp_r;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
				return;
			end
			exp_r = pending.pop_front();
			if (got.ok !== exp_r.ok || got.start !== exp_r.start || got.free_n !== exp_r.free_n
				|| got.used_n !== exp_r.used_n || got.avail_n !== exp_r.avail_n) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: exp ok=%0d start=%0d free=%0d used=%0d avail=%0d",
						" / got ok=%0d start=%0d free=%0d used=%0d avail=%0d"},
						exp_r.ok, exp_r.start, exp_r.free_n, exp_r.used_n, exp_r.avail_n,
						got.ok, got.start, got.free_n, got.used_n, got.avail_n);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [16:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  op = '0;
	logic [16:0] frame_count = '0;
	logic [1:0]  mem_type = '0;
	logic [15:0] base_frame = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        ok;
	logic [15:0] start_frame;
	logic [19:0] free_frames, used_frames, available_frames;

	frame_scoreboard sb = new();
	int          tx_idle_pct = 21;
	int          rx_idle_pct = 84;
	int unsigned cycle_cnt = 0;
	logic [15:0] live_start [$];
	logic [16:0] live_len [$];

	bitmap_frame_allocator_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .frame_count(frame_count), .mem_type(mem_type), .base_frame(base_frame),
		.out_valid(out_valid), .out_ready(out_ready),
		.ok(ok), .start_frame(start_frame), .free_frames(free_frames),
		.used_frames(used_frames), .available_frames(available_frames)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// stall the result channel at random
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// check every result beat
	always @(posedge clk) begin
		alloc_res_t got;
		if (out_valid && out_ready) begin
			got.ok = ok; got.start = start_frame; got.free_n = free_frames;
			got.used_n = used_frames; got.avail_n = available_frames;
			sb.check(got);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// drive one input beat; valid stays up if the next beat follows at once
	task automatic send_beat(bfa_pkg::op_t o, logic [16:0] cnt, logic [1:0] mt,
			logic [15:0] base);
		alloc_res_t r;
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1; op = o; frame_count = cnt; mem_type = mt; base_frame = base;
		do @(posedge clk); while (!in_ready);
		r = sb.note(o, cnt, mt, base);
		if (o == bfa_pkg::OP_INIT) begin
			live_start.delete(); live_len.delete();
		end else if (o == bfa_pkg::OP_ALLOC && r.ok) begin
			live_start.push_back(r.start); live_len.push_back(cnt);
		end
	endtask

	// drop valid and wait until all results are back
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_regions(logic [15:0] ns, logic [16:0] nl, logic [15:0] fs,
			logic [16:0] fl);
		logic [16:0] vals [4];
		vals[0] = 17'(ns); vals[1] = nl; vals[2] = 17'(fs); vals[3] = fl;
		for (int i = 0; i < 4; i++) begin
			@(negedge clk);
			cfg_we = 1'b1; cfg_index = 2'(i); cfg_data = vals[i];
			sb.set_reg(2'(i), vals[i]);
		end
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// one random beat, biased toward allocations and frees of live runs
	task automatic random_beat();
		int unsigned sel, k;
		logic [16:0] cnt;
		sel = $urandom_range(99);
		cnt = ($urandom_range(9) == 0) ? 17'($urandom_range(65536))
			: 17'($urandom_range(1, 40));
		if ($urandom_range(40) == 0) cnt = '0;
		if (sel < 4) begin
			send_beat(bfa_pkg::OP_INIT, 17'($urandom), 2'($urandom), 16'($urandom));
		end else if (sel < 55) begin
			send_beat(bfa_pkg::OP_ALLOC, cnt, ($urandom_range(9) == 0) ? 2'($urandom)
				: 2'($urandom_range(1)), 16'($urandom));
		end else if (sel < 80 && live_start.size() != 0) begin
			k = $urandom_range(live_start.size() - 1);
			send_beat(bfa_pkg::OP_FREE, live_len[k], 2'($urandom), live_start[k]);
			live_start.delete(k); live_len.delete(k);
		end else begin
			send_beat(($urandom_range(1) != 0) ? bfa_pkg::OP_FREE : bfa_pkg::OP_MARK, cnt,
				2'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		logic [15:0] ns_t [6];
		logic [16:0] nl_t [6];
		logic [15:0] fs_t [6];
		logic [16:0] fl_t [6];
		int          sent;

		ns_t = '{16'd1024, 16'd0,     16'd65535, 16'd300, 16'd0, 16'd5000};
		nl_t = '{17'd8192, 17'd65536, 17'd65536, 17'd500, 17'd0, 17'd1000};
		fs_t = '{16'd60000, 16'd65535, 16'd0, 16'd100, 16'd0, 16'd5500};
		fl_t = '{17'd2000, 17'd1,     17'd0,  17'd500, 17'd0, 17'd1000};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (!in_ready) @(negedge clk);

		// directed: region edges, every operation, every failure path
		write_regions(16'd2048, 17'd4096, 16'd40000, 17'd300);
		send_beat(bfa_pkg::OP_INIT, '0, bfa_pkg::MEM_NORMAL, '0);
		send_beat(bfa_pkg::OP_ALLOC, 17'd1, bfa_pkg::MEM_NORMAL, '0);
		send_beat(bfa_pkg::OP_ALLOC, 17'd0, bfa_pkg::MEM_NORMAL, '0);
		send_beat(bfa_pkg::OP_ALLOC, 17'd1, 2'd2, '0);
		send_beat(bfa_pkg::OP_ALLOC, 17'd1, 2'd3, 16'hffff);
		send_beat(bfa_pkg::OP_ALLOC, 17'd65536, bfa_pkg::MEM_NORMAL, '0);
		send_beat(bfa_pkg::OP_ALLOC, 17'd301, bfa_pkg::MEM_FAST, '0);
		send_beat(bfa_pkg::OP_ALLOC, 17'd300, bfa_pkg::MEM_FAST, '0);
		send_beat(bfa_pkg::OP_ALLOC, 17'd1, bfa_pkg::MEM_FAST, '0);
		send_beat(bfa_pkg::OP_FREE, 17'd300, bfa_pkg::MEM_FAST, 16'd40000);
		send_beat(bfa_pkg::OP_MARK, 17'd65536, bfa_pkg::MEM_NORMAL, 16'hffff);
		send_beat(bfa_pkg::OP_FREE, 17'd65536, bfa_pkg::MEM_NORMAL, 16'hffff);
		send_beat(bfa_pkg::OP_FREE, 17'd0, bfa_pkg::MEM_NORMAL, 16'd2048);
		send_beat(bfa_pkg::OP_MARK, 17'd0, bfa_pkg::MEM_NORMAL, 16'd2048);
		send_beat(bfa_pkg::OP_ALLOC, 17'd4000, bfa_pkg::MEM_NORMAL, '0);
		send_beat(bfa_pkg::OP_ALLOC, 17'd200, bfa_pkg::MEM_NORMAL, '0);
		send_beat(bfa_pkg::OP_MARK, 17'd1, bfa_pkg::MEM_NORMAL, 16'd0);
		send_beat(bfa_pkg::OP_INIT, 17'h1ffff, 2'd3, 16'hffff);
		drain();

		// random phases over several region settings
		sent = 0;
		for (int ph = 0; ph < 6; ph++) begin
			write_regions(ns_t[ph], nl_t[ph], fs_t[ph], fl_t[ph]);
			send_beat(bfa_pkg::OP_INIT, '0, bfa_pkg::MEM_NORMAL, '0);
			sent++;
			for (int n = 0; n < 48; n++) begin
				if (sent < 97) begin
					tx_idle_pct = 21; rx_idle_pct = 84;
				end else if (sent < 194) begin
					tx_idle_pct = 84; rx_idle_pct = 21;
				end else begin
					tx_idle_pct = 0; rx_idle_pct = 0;
				end
				// hold off until the result channel is empty
				if (ph == 2 && n == 24) begin
					@(negedge clk);
					in_valid = 1'b0;
					while (sb.pending.size() != 0) @(negedge clk);
				end
				random_beat();
				sent++;
			end
			drain();
		end

		repeat (50) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
